FILE: hdl/csv_field_tokenizer_top_assert.svh
// Assertion macros for the CSV tokenizer checker.
`ifndef CSV_FIELD_TOKENIZER_TOP_ASSERT_SVH
`define CSV_FIELD_TOKENIZER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define CSVT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("csv tokenizer check failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define CSVT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("csv tokenizer check failed");

`endif

FILE: hdl/csvt_pkg.sv
`timescale 1ns / 1ps

package csvt_pkg;

  localparam int unsigned ColW    = 10;
  localparam int unsigned MaxRes  = 2;  // at most two results per input beat
  localparam int unsigned CntW    = $clog2(MaxRes + 1);
  localparam int unsigned IdxW    = $clog2(MaxRes);

  localparam logic [ColW-1:0] ColMax = '1;

  localparam logic [7:0] ChComma = 8'h2C;
  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChNl    = 8'h0A;

  typedef enum logic [1:0] {
    REQ_BYTE = 2'd0,
    REQ_EOL  = 2'd1,
    REQ_EOI  = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    KIND_CELL  = 2'd0,
    KIND_FIELD = 2'd1,
    KIND_ROW   = 2'd2
  } kind_e;

  typedef struct packed {
    logic            in_quotes;
    logic            quote_pending;
    logic            newline_pending;
    logic            line_has_bytes;
    logic            ended_on_sep;
    logic [ColW-1:0] col;
  } state_t;

  typedef struct packed {
    kind_e           kind;
    logic [7:0]      ch;
    logic [ColW-1:0] col;
  } res_t;

  typedef struct packed {
    res_t [MaxRes-1:0] res;
    logic [CntW-1:0]   cnt;
    state_t            nxt;
  } step_t;

  function automatic res_t make_res(kind_e k, logic [7:0] c, logic [ColW-1:0] col);
    res_t r;
    r.kind = k;
    r.ch   = c;
    r.col  = col;
    return r;
  endfunction

  function automatic logic [ColW-1:0] col_inc(logic [ColW-1:0] col);
    return (col == ColMax) ? col : col + 1'b1;
  endfunction

endpackage

FILE: hdl/csv_field_tokenizer_top.sv
`timescale 1ns / 1ps

// Latency: first result of a beat shows on the outputs the cycle after acceptance.
// Throughput: one input beat per cycle while each beat yields at most one result and the
//   receiver does not stall; a beat with two results stalls the input until one has drained.
// Reset: rst_ni is asynchronous, active low; it clears parser state and the result buffer.
module csv_field_tokenizer_top import csvt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  // input channel
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] req_type_i,
  input  logic [7:0] ch_i,
  // result channel
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] out_kind_o,
  output logic [7:0] out_char_o,
  output logic [9:0] column_index_o,
  output logic       last_of_run_o
);

  // Parser flags and the running column live here; all per-beat decisions are
  // made by csvt_step in the same cycle the beat is accepted.
  state_t state_q, state_d;
  step_t  step;

  // Result buffer: holds the whole run of one beat, drained one per cycle while out_stall_i is low.
  res_t [MaxRes-1:0] res_q, res_d;
  logic [CntW-1:0]   cnt_q, cnt_d;   // results still to deliver
  logic [IdxW-1:0]   rd_q, rd_d;     // slot shown on the outputs

  logic in_fire, out_fire;

  csvt_step u_step (
    .req_i   (req_type_i),
    .ch_i    (ch_i),
    .state_i (state_q),
    .step_o  (step)
  );

  assign out_valid_o = (cnt_q != '0);
  assign out_fire    = out_valid_o && !out_stall_i;

  // Take a new beat when the buffer is empty or its last result leaves now.
  assign in_stall_o = (cnt_q > CntW'(1)) || ((cnt_q == CntW'(1)) && out_stall_i);
  assign in_fire    = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    res_d   = res_q;
    cnt_d   = cnt_q;
    rd_d    = rd_q;
    if (out_fire) begin
      cnt_d = cnt_q - 1'b1;
      rd_d  = rd_q + 1'b1;
    end
    if (in_fire) begin
      state_d = step.nxt;
      res_d   = step.res;
      cnt_d   = step.cnt;
      rd_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
      cnt_q   <= '0;
      rd_q    <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      rd_q    <= rd_d;
    end
  end

  // payload: no reset needed
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_kind_o     = res_q[rd_q].kind;
  assign out_char_o     = res_q[rd_q].ch;
  assign column_index_o = res_q[rd_q].col;
  assign last_of_run_o  = (cnt_q == CntW'(1));

endmodule

FILE: hdl/csvt_step.sv
`timescale 1ns / 1ps

// Next state and result list for one input beat.
module csvt_step import csvt_pkg::*; (
  input  logic [1:0] req_i,
  input  logic [7:0] ch_i,
  input  state_t     state_i,
  output step_t      step_o
);

  logic   is_byte, is_eol, is_eoi;
  logic   done;
  state_t s;
  res_t [MaxRes-1:0] res;
  logic [CntW-1:0]   n;

  always_comb begin
    is_byte = 1'b0;
    is_eol  = 1'b0;
    is_eoi  = 1'b0;
    case (req_e'(req_i))
      REQ_BYTE: is_byte = 1'b1;
      REQ_EOL:  is_eol  = 1'b1;
      REQ_EOI:  is_eoi  = 1'b1;
      default:  ;  // unused code: no results, state kept
    endcase
  end

  always_comb begin
    s    = state_i;
    res  = '0;
    n    = '0;
    done = 1'b0;

    if (is_byte) begin
      // owed newline from a line end inside quotes
      if (!s.line_has_bytes && s.newline_pending) begin
        res[n[IdxW-1:0]] = make_res(KIND_CELL, ChNl, s.col);
        n = n + 1'b1;
        s.newline_pending = 1'b0;
      end
      s.line_has_bytes = 1'b1;
      if (s.quote_pending) begin
        s.quote_pending = 1'b0;
        if (ch_i == ChQuote) begin
          res[n[IdxW-1:0]] = make_res(KIND_CELL, ChQuote, s.col);
          n = n + 1'b1;
          s.ended_on_sep = 1'b0;
          done = 1'b1;
        end else begin
          s.in_quotes = !s.in_quotes;
        end
      end
      if (!done) begin
        if (ch_i == ChQuote) begin
          s.quote_pending = 1'b1;
          s.ended_on_sep  = 1'b0;
        end else if (ch_i == ChComma && !s.in_quotes) begin
          res[n[IdxW-1:0]] = make_res(KIND_FIELD, 8'h00, s.col);
          n = n + 1'b1;
          s.col = col_inc(s.col);
          s.ended_on_sep = 1'b1;
        end else begin
          res[n[IdxW-1:0]] = make_res(KIND_CELL, ch_i, s.col);
          n = n + 1'b1;
          s.ended_on_sep = 1'b0;
        end
      end
    end

    // line end, also applied first by end of input mid-line
    if (is_eol || (is_eoi && (s.line_has_bytes || s.quote_pending))) begin
      if (s.quote_pending) begin
        s.quote_pending = 1'b0;
        s.in_quotes = !s.in_quotes;
      end
      if (s.in_quotes) begin
        if (s.line_has_bytes) s.newline_pending = 1'b1;
      end else begin
        if (s.line_has_bytes && !s.ended_on_sep) begin
          res[n[IdxW-1:0]] = make_res(KIND_FIELD, 8'h00, s.col);
          n = n + 1'b1;
          s.col = col_inc(s.col);
        end
        res[n[IdxW-1:0]] = make_res(KIND_ROW, 8'h00, s.col);
        n = n + 1'b1;
        s.col = '0;
        s.newline_pending = 1'b0;
      end
      s.line_has_bytes = 1'b0;
      s.ended_on_sep   = 1'b0;
    end

    if (is_eoi) begin
      if (s.in_quotes) begin
        if (s.newline_pending) begin
          res[n[IdxW-1:0]] = make_res(KIND_FIELD, 8'h00, s.col);
          n = n + 1'b1;
          s.col = col_inc(s.col);
        end
        res[n[IdxW-1:0]] = make_res(KIND_ROW, 8'h00, s.col);
        n = n + 1'b1;
      end
      s = '0;
    end

    step_o.res = res;
    step_o.cnt = n;
    step_o.nxt = s;
  end

endmodule

FILE: hdl/csvt_checker.sv
`timescale 1ns / 1ps

`include "csv_field_tokenizer_top_assert.svh"

module csvt_checker import csvt_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] out_kind_o,
  input logic [7:0] out_char_o,
  input logic [9:0] column_index_o,
  input logic       last_of_run_o
);

  // stalled result beat holds
  `CSVT_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_kind_o) && $stable(out_char_o) && $stable(column_index_o) && $stable(last_of_run_o))

  // nothing buffered means input is open
  `CSVT_ASSERT_NOW(a_idle_open, !out_valid_o, !in_stall_o)

  // only cell bytes carry a character
  `CSVT_ASSERT_NOW(a_char_zero, out_valid_o && (out_kind_o != KIND_CELL), out_char_o == 8'h00)

  // a row end always closes its run
  `CSVT_ASSERT_NOW(a_row_last, out_valid_o && (out_kind_o == KIND_ROW), last_of_run_o)

endmodule

bind csv_field_tokenizer_top csvt_checker u_csvt_checker (.*);

FILE: tb/tb_csv_field_tokenizer_top.sv
`timescale 1ns / 1ps

// Self-checking bench for the streaming CSV tokenizer.
// A sender walks a short directed table, then random CSV lines mixed with noise.
// A receiver takes results with random stalls. Every accepted input beat goes
// through a behavioral tokenizer here, and each accepted result beat is compared
// field by field with the oldest expectation.
module tb_csv_field_tokenizer_top import csvt_pkg::*;;

  // Byte values the tokenizer reacts to
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_QUOTE = 8'h22;
  localparam logic [7:0] CHAR_NL    = 8'h0A;
  // req_type code with no meaning; the block must swallow it silently
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam logic [9:0] COL_SAT    = 10'd1023;

  localparam int ITEMS_TARGET = 430;   // input beats in the whole run
  localparam int HOLD_AT      = 60;    // result count at which the receiver holds off
  localparam int HOLD_LEN     = 150;   // cycles of that hold-off
  localparam int DRAIN_CYCLES = 20;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [1:0] req_type_i;
  logic [7:0] ch_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [1:0] out_kind_o;
  logic [7:0] out_char_o;
  logic [9:0] column_index_o;
  logic       last_of_run_o;

  // One result beat as the tokenizer should emit it
  typedef struct packed {
    kind_e      kind;
    logic [7:0] ch;
    logic [9:0] col;
    logic       last;
  } tok_t;

  // One row of the directed table; typed rows carry their single expected token
  typedef struct {
    logic [1:0] req;
    logic [7:0] ch;
    bit         typed;
    tok_t       tok;
  } dir_row_t;

  tok_t     exp_tokens[$];   // tokens still owed by the block, oldest first
  tok_t     beat_tokens[$];  // tokens caused by the beat just accepted
  dir_row_t dir_rows[$];

  // Tokenizer state, mirrors the block
  bit         quoted       = 1'b0;
  bit         quote_seen   = 1'b0;  // quote waiting for the next byte to decide
  bit         nl_owed      = 1'b0;  // line ended inside quotes
  bit         line_started = 1'b0;
  bit         sep_last     = 1'b0;  // last byte of line was an unquoted comma
  logic [9:0] col_cnt      = '0;

  bit burst_mode = 1'b0;  // both sides run without random idle gaps
  int mismatches = 0;
  int beats_sent = 0;

  csv_field_tokenizer_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .ch_i           (ch_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_kind_o     (out_kind_o),
    .out_char_o     (out_char_o),
    .column_index_o (column_index_o),
    .last_of_run_o  (last_of_run_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Behavioral tokenizer
  // ---------------------------------------------------------------------------
  function automatic void put_tok(kind_e k, logic [7:0] c);
    tok_t t;
    t.kind = k;
    t.ch   = c;
    t.col  = col_cnt;
    t.last = 1'b0;
    beat_tokens = {beat_tokens, t};
  endfunction

  function automatic void end_field();
    put_tok(KIND_FIELD, 8'h00);
    if (col_cnt != COL_SAT) col_cnt = col_cnt + 1'b1;
  endfunction

  function automatic void end_row();
    put_tok(KIND_ROW, 8'h00);
    col_cnt = '0;
  endfunction

  function automatic void take_byte(logic [7:0] c);
    // first byte of a line continuing a quoted field brings the owed newline
    if (!line_started && nl_owed) begin
      put_tok(KIND_CELL, CHAR_NL);
      nl_owed = 1'b0;
    end
    line_started = 1'b1;
    if (quote_seen) begin
      quote_seen = 1'b0;
      if (c == CHAR_QUOTE) begin
        // doubled quote: literal quote, in or out of quotes
        put_tok(KIND_CELL, CHAR_QUOTE);
        sep_last = 1'b0;
        return;
      end
      quoted = !quoted;
    end
    if (c == CHAR_QUOTE) begin
      quote_seen = 1'b1;
      sep_last   = 1'b0;
    end else if (c == CHAR_COMMA && !quoted) begin
      end_field();
      sep_last = 1'b1;
    end else begin
      put_tok(KIND_CELL, c);
      sep_last = 1'b0;
    end
  endfunction

  function automatic void take_eol();
    // a quote still pending at line end toggles quoting
    if (quote_seen) begin
      quote_seen = 1'b0;
      quoted     = !quoted;
    end
    if (quoted) begin
      // field stays open; empty quoted lines add nothing
      if (line_started) nl_owed = 1'b1;
    end else begin
      // trailing comma drops the empty last field
      if (line_started && !sep_last) end_field();
      end_row();
      nl_owed = 1'b0;
    end
    line_started = 1'b0;
    sep_last     = 1'b0;
  endfunction

  function automatic void take_eoi();
    if (line_started || quote_seen) take_eol();
    if (quoted) begin
      if (nl_owed) end_field();
      end_row();
    end
    quoted       = 1'b0;
    quote_seen   = 1'b0;
    nl_owed      = 1'b0;
    line_started = 1'b0;
    sep_last     = 1'b0;
    col_cnt      = '0;
  endfunction

  // Fills beat_tokens with what one input beat causes, last one flagged
  function automatic void tokenize(logic [1:0] req, logic [7:0] c);
    tok_t t;
    beat_tokens.delete();
    case (req)
      REQ_BYTE: take_byte(c);
      REQ_EOL:  take_eol();
      REQ_EOI:  take_eoi();
      default:  ;  // unused code: nothing happens
    endcase
    if (beat_tokens.size() > 0) begin
      t = beat_tokens.pop_back();
      t.last = 1'b1;
      beat_tokens = {beat_tokens, t};
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  // Offers one beat after a random gap (none in burst mode) and waits for it to be taken.
  // Returns at the accepting edge without touching in_valid_i, so back-to-back beats
  // keep valid high.
  task automatic push_beat(input logic [1:0] req, input logic [7:0] c,
                           input bit use_typed = 1'b0, input tok_t typed_tok = '0);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      // junk on the payload while valid is low
      in_valid_i <= 1'b0;
      req_type_i <= 2'($urandom_range(0, 3));
      ch_i       <= 8'($urandom_range(0, 255));
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= req;
    ch_i       <= c;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    tokenize(req, c);
    if (use_typed) exp_tokens = {exp_tokens, typed_tok};
    else exp_tokens = {exp_tokens, beat_tokens};
    beats_sent++;
  endtask

  function automatic void add_row(logic [1:0] req, logic [7:0] c, bit typed = 1'b0,
                                  kind_e k = KIND_CELL, logic [7:0] oc = 8'h00,
                                  logic [9:0] col = '0);
    dir_row_t r;
    r.req      = req;
    r.ch       = c;
    r.typed    = typed;
    r.tok.kind = k;
    r.tok.ch   = oc;
    r.tok.col  = col;
    r.tok.last = 1'b1;
    dir_rows = {dir_rows, r};
  endfunction

  // Random byte that is neither a quote nor a comma
  function automatic logic [7:0] plain_byte();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    if (c == CHAR_QUOTE || c == CHAR_COMMA) c = 8'h41;
    return c;
  endfunction

  // One well-formed CSV line: mixed plain and quoted fields, random content
  task automatic push_csv_line();
    int nf;
    int len;
    nf = $urandom_range(1, 5);
    for (int f = 0; f < nf; f++) begin
      if (f > 0) push_beat(REQ_BYTE, CHAR_COMMA);
      len = $urandom_range(0, 4);
      if ($urandom_range(0, 1)) begin
        push_beat(REQ_BYTE, CHAR_QUOTE);
        for (int i = 0; i < len; i++) begin
          case ($urandom_range(0, 5))
            0: push_beat(REQ_BYTE, CHAR_COMMA);
            1: begin
              push_beat(REQ_BYTE, CHAR_QUOTE);
              push_beat(REQ_BYTE, CHAR_QUOTE);
            end
            2: push_beat(REQ_EOL, 8'($urandom_range(0, 255)));  // line break inside quotes
            default: push_beat(REQ_BYTE, plain_byte());
          endcase
        end
        push_beat(REQ_BYTE, CHAR_QUOTE);
      end else begin
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 7) == 0) begin
            push_beat(REQ_BYTE, CHAR_QUOTE);
            push_beat(REQ_BYTE, CHAR_QUOTE);
          end else begin
            push_beat(REQ_BYTE, plain_byte());
          end
        end
      end
    end
    if ($urandom_range(0, 4) == 0) push_beat(REQ_BYTE, CHAR_COMMA);
    push_beat(REQ_EOL, 8'($urandom_range(0, 255)));
  endtask

  // Broken sequences: stray quotes and commas, early line or input ends
  task automatic push_noise();
    int n;
    n = $urandom_range(1, 6);
    repeat (n) begin
      case ($urandom_range(0, 7))
        0, 1: push_beat(REQ_BYTE, CHAR_QUOTE);
        2:    push_beat(REQ_BYTE, CHAR_COMMA);
        3, 4: push_beat(REQ_BYTE, 8'($urandom_range(0, 255)));
        5:    push_beat(REQ_EOL, 8'($urandom_range(0, 255)));
        6:    push_beat(REQ_EOI, 8'($urandom_range(0, 255)));
        default: push_beat(REQ_UNUSED, 8'($urandom_range(0, 255)));
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side
  // ---------------------------------------------------------------------------
  task automatic check_result();
    tok_t want;
    if (exp_tokens.size() == 0) begin
      $display("%0t: unexpected result: kind %0d char %02h col %0d last %0b", $time,
               out_kind_o, out_char_o, column_index_o, last_of_run_o);
      mismatches++;
    end else begin
      want = exp_tokens.pop_front();
      if (out_kind_o !== want.kind) begin
        $display("%0t: out_kind expected %0d, got %0d", $time, want.kind, out_kind_o);
        mismatches++;
      end
      if (out_char_o !== want.ch) begin
        $display("%0t: out_char expected %02h, got %02h", $time, want.ch, out_char_o);
        mismatches++;
      end
      if (column_index_o !== want.col) begin
        $display("%0t: column_index expected %0d, got %0d", $time, want.col,
                 column_index_o);
        mismatches++;
      end
      if (last_of_run_o !== want.last) begin
        $display("%0t: last_of_run expected %0b, got %0b", $time, want.last,
                 last_of_run_o);
        mismatches++;
      end
    end
  endtask

  initial begin : result_sink
    int hold;
    int n_seen;
    n_seen = 0;
    out_stall_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      hold = burst_mode ? 0 : $urandom_range(0, 8);
      // one long hold-off: the block fills up and must stall its input
      if (n_seen == HOLD_AT) hold = HOLD_LEN;
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      check_result();
      n_seen++;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int pick;
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    req_type_i <= REQ_BYTE;
    ch_i       <= 8'h00;

    // Directed table; rows with a typed token are checked against it directly
    add_row(REQ_BYTE, 8'h61, 1'b1, KIND_CELL, 8'h61, 10'd0);       // plain byte after reset
    add_row(REQ_BYTE, 8'h00, 1'b1, KIND_CELL, 8'h00, 10'd0);       // low extreme
    add_row(REQ_BYTE, 8'hFF, 1'b1, KIND_CELL, 8'hFF, 10'd0);       // high extreme
    add_row(REQ_BYTE, CHAR_COMMA, 1'b1, KIND_FIELD, 8'h00, 10'd0); // unquoted comma
    add_row(REQ_BYTE, CHAR_QUOTE);                                 // quote held back
    add_row(REQ_BYTE, CHAR_QUOTE, 1'b1, KIND_CELL, CHAR_QUOTE, 10'd1); // doubled, unquoted
    add_row(REQ_BYTE, CHAR_QUOTE);
    add_row(REQ_BYTE, 8'h78);                                      // lone quote opens quoting
    add_row(REQ_BYTE, CHAR_COMMA);                                 // comma inside quotes
    add_row(REQ_EOL, 8'h00);                                       // line end inside quotes
    add_row(REQ_EOL, 8'hFF);                                       // empty quoted line
    add_row(REQ_BYTE, 8'h79);                                      // owed newline, then byte
    add_row(REQ_BYTE, CHAR_QUOTE);
    add_row(REQ_EOL, 8'h00);                                       // quote pending at line end
    add_row(REQ_EOL, 8'h00, 1'b1, KIND_ROW, 8'h00, 10'd0);         // empty line
    add_row(REQ_BYTE, 8'h61);
    add_row(REQ_BYTE, CHAR_COMMA);
    add_row(REQ_EOL, 8'h00, 1'b1, KIND_ROW, 8'h00, 10'd1);         // trailing comma
    add_row(REQ_BYTE, CHAR_QUOTE);
    add_row(REQ_BYTE, 8'h71);
    add_row(REQ_EOL, 8'h00);
    add_row(REQ_EOI, 8'h00);                                       // input ends inside quotes
    add_row(REQ_UNUSED, 8'h7A);                                    // unused code, ignored
    add_row(REQ_BYTE, 8'h0D, 1'b1, KIND_CELL, 8'h0D, 10'd0);       // CR is ordinary
    add_row(REQ_BYTE, CHAR_NL, 1'b1, KIND_CELL, CHAR_NL, 10'd0);   // LF is ordinary
    add_row(REQ_EOI, 8'h00);                                       // input ends mid line
    add_row(REQ_BYTE, CHAR_QUOTE);
    add_row(REQ_EOI, 8'hFF);                                       // input ends on a quote

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i])
      push_beat(dir_rows[i].req, dir_rows[i].ch, dir_rows[i].typed, dir_rows[i].tok);

    // Random part: mostly well-formed lines, some noise and early input ends
    while (beats_sent < ITEMS_TARGET) begin
      burst_mode = ($urandom_range(0, 4) == 0);
      pick = $urandom_range(0, 9);
      if (pick < 7) push_csv_line();
      else if (pick < 9) push_noise();
      else push_beat(REQ_EOI, 8'($urandom_range(0, 255)));
    end
    burst_mode = 1'b0;
    in_valid_i <= 1'b0;

    while (exp_tokens.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && exp_tokens.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Hard limit, far above the slowest legal run
  initial begin : watchdog
    #(2_000_000);
    $display("timeout, %0d tokens still owed", exp_tokens.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
